[sv/nvrs_pkg.sv]
// Shared types and constants of the nearest-value request scheduler.
// Used by nvrs_cell and nearest_value_request_scheduler; depends on nothing.
package nvrs_pkg;

   localparam int SLOTS_DEF     = 16;
   localparam int REQ_COUNT_DEF = 16;

   localparam int OPCODE_W = 2;
   localparam int OWNER_W  = 4;
   localparam int VALUE_W  = 10;
   localparam int STATUS_W = 2;
   localparam int SIZE_W   = 5;
   localparam int DIST_W   = 11;
   localparam int LAST_W   = 11;
   // Slot index width for the largest supported board of 256 slots.
   localparam int IDX_W    = 8;

   localparam logic [OPCODE_W-1:0] OP_POST  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_JOIN  = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_LEAVE = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_CLOSED = 2'd3;

   localparam logic [VALUE_W-1:0]       VALUE_LIMIT = 10'd1000;
   localparam logic [DIST_W-1:0]        DIST_START  = 11'd1005;
   localparam logic signed [LAST_W-1:0] LAST_RESET  = -11'sd1;
   localparam logic [SIZE_W-1:0]        SIZE_RESET  = 5'd16;

   // Token that walks the slot chain: it carries a pending post and the
   // best candidate found so far.
   typedef struct packed {
      logic               active;
      logic               pending;
      logic [VALUE_W-1:0] value;
      logic [OWNER_W-1:0] owner;
      logic               free_seen;
      logic               found;
      logic [DIST_W-1:0]  best_dist;
      logic [IDX_W-1:0]   best_idx;
      logic [VALUE_W-1:0] best_value;
      logic [OWNER_W-1:0] best_owner;
   } sweep_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
   } clear_type;

endpackage

[sv/nearest_value_request_scheduler.sv]
// Top level of the nearest-value request scheduler: control, counters and the slot chain.
// Depends on nvrs_pkg and nvrs_cell.
//
// Each event (post, join, leave) is taken on start while busy is low and gives
// exactly one result beat on rsp_valid, registered after the token leaves the slot
// chain. The token walks the cells one slot per cycle, placing a pending post in
// the first free slot and picking the request nearest the last served value on
// the way. Busy stays high from the event until the cycle in which its result
// beat is shown, and a new event may be started in that cycle. The result beat
// cannot be held off. Board size writes are taken while busy is low.
module nearest_value_request_scheduler #(
   parameter int SLOTS           = nvrs_pkg::SLOTS_DEF,
   parameter int REQUESTER_COUNT = nvrs_pkg::REQ_COUNT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [nvrs_pkg::OPCODE_W-1:0]    req_opcode,
   input  logic [nvrs_pkg::OWNER_W-1:0]     req_requester,
   input  logic [nvrs_pkg::VALUE_W-1:0]     req_value,
   output logic                             rsp_valid,
   output logic [nvrs_pkg::STATUS_W-1:0]    rsp_status,
   output logic                             rsp_served,
   output logic [nvrs_pkg::OWNER_W-1:0]     rsp_served_requester,
   output logic [nvrs_pkg::VALUE_W-1:0]     rsp_served_value,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nvrs_pkg::SIZE_W-1:0]      csr_data
);
   import nvrs_pkg::*;

   localparam int OccW = $clog2(SLOTS + 1);
   localparam int ActW = $clog2(REQUESTER_COUNT + 1);

   typedef enum logic {S_IDLE, S_SWEEP} state_type;

   state_type                state_ff;
   logic [SIZE_W-1:0]        board_size_ff;
   logic [OccW-1:0]          occ_ff;
   logic [ActW-1:0]          act_ff;
   logic signed [LAST_W-1:0] last_ff;
   logic                     closed_ff;
   logic                     post_ok_ff;
   logic [STATUS_W-1:0]      status_ff;
   sweep_type                head_ff;
   logic                     rsp_valid_ff;
   logic [STATUS_W-1:0]      rsp_status_ff;
   logic                     rsp_served_ff;
   logic [OWNER_W-1:0]       rsp_owner_ff;
   logic [VALUE_W-1:0]       rsp_value_ff;

   sweep_type                chain [SLOTS+1];
   logic [SLOTS-1:0]         in_range;
   logic [SLOTS:0]           token_vec;
   clear_type                clear;

   logic                     accept;
   logic [STATUS_W-1:0]      acc_status;
   logic                     acc_post_ok;
   logic [ActW-1:0]          act_in;
   logic                     closed_in;

   sweep_type                tail;
   logic                     done;
   logic                     placed;
   logic [OccW-1:0]          occ_new;
   logic                     serve;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = !busy;

   // Event decode: everything but the slot placement and the serve decision is settled here.
   always_comb begin
      acc_status  = STAT_CLOSED;
      acc_post_ok = 1'b0;
      act_in      = act_ff;
      closed_in   = closed_ff;
      case (req_opcode)
         OP_POST: begin
            if (closed_ff || act_ff == '0) begin
               acc_status = STAT_CLOSED;
            end else if (req_value >= VALUE_LIMIT) begin
               acc_status = STAT_RANGE;
            end else begin
               acc_status  = STAT_OK;
               acc_post_ok = 1'b1;
            end
         end
         OP_JOIN: begin
            if (closed_ff) begin
               acc_status = STAT_CLOSED;
            end else if (act_ff >= ActW'(REQUESTER_COUNT)) begin
               acc_status = STAT_FULL;
            end else begin
               acc_status = STAT_OK;
               act_in     = act_ff + ActW'(1);
            end
         end
         OP_LEAVE: begin
            if (closed_ff || act_ff == '0) begin
               acc_status = STAT_CLOSED;
            end else begin
               acc_status = STAT_OK;
               act_in     = act_ff - ActW'(1);
               closed_in  = (act_ff == ActW'(1));
            end
         end
         default: begin
            acc_status = STAT_CLOSED;
         end
      endcase
   end

   assign chain[0] = head_ff;

   for (genvar i = 0; i < SLOTS; i++) begin : g_slot
      // A board size of zero acts as one slot; sizes beyond SLOTS cover all.
      assign in_range[i]  = (i == 0) || (32'(board_size_ff) > i);
      assign token_vec[i] = chain[i].active;
      nvrs_cell #(
         .Index (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .sweep_i     (chain[i]),
         .sweep_o     (chain[i+1]),
         .in_range    (in_range[i]),
         .last_served (last_ff),
         .clear       (clear)
      );
   end
   assign token_vec[SLOTS] = chain[SLOTS].active;

   // The token leaving the last cell carries the serve decision inputs.
   assign tail    = chain[SLOTS];
   assign done    = (state_ff == S_SWEEP) && tail.active;
   assign placed  = post_ok_ff && !tail.pending;
   assign occ_new = occ_ff + OccW'(placed);
   assign serve   = !closed_ff && (occ_new != '0) && tail.found &&
                    (!tail.free_seen || 32'(occ_new) == 32'(act_ff));

   assign clear.en  = done && serve;
   assign clear.idx = tail.best_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         board_size_ff  <= SIZE_RESET;
         occ_ff         <= '0;
         act_ff         <= '0;
         last_ff        <= LAST_RESET;
         closed_ff      <= 1'b0;
         head_ff.active <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         head_ff.active <= accept;
         rsp_valid_ff   <= done;
         if (csr_valid && csr_ready) begin
            board_size_ff <= csr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff   <= S_SWEEP;
                  act_ff     <= act_in;
                  closed_ff  <= closed_in;
                  post_ok_ff <= acc_post_ok;
                  status_ff  <= acc_status;
                  head_ff.pending    <= acc_post_ok;
                  head_ff.value      <= req_value;
                  head_ff.owner      <= req_requester;
                  head_ff.free_seen  <= 1'b0;
                  head_ff.found      <= 1'b0;
                  head_ff.best_dist  <= DIST_START;
                  head_ff.best_idx   <= '0;
                  head_ff.best_value <= '0;
                  head_ff.best_owner <= '0;
               end
            end
            S_SWEEP: begin
               if (done) begin
                  state_ff      <= S_IDLE;
                  rsp_status_ff <= (post_ok_ff && tail.pending) ? STAT_FULL : status_ff;
                  rsp_served_ff <= serve;
                  if (serve) begin
                     occ_ff       <= occ_new - OccW'(1);
                     last_ff      <= $signed({1'b0, tail.best_value});
                     rsp_owner_ff <= tail.best_owner;
                     rsp_value_ff <= tail.best_value;
                  end else begin
                     occ_ff       <= occ_new;
                     rsp_owner_ff <= '0;
                     rsp_value_ff <= '0;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_served           = rsp_served_ff;
   assign rsp_served_requester = rsp_owner_ff;
   assign rsp_served_value     = rsp_value_ff;

   // An accepted event yields its result beat after the full chain walk.
   a_result_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(SLOTS + 2) rsp_valid)
      else $error("result beat missing after chain walk");

   // Only one token walks the chain at a time.
   a_single_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0(token_vec))
      else $error("more than one sweep token in the chain");

   // A served beat leaves its value as the new last served value.
   a_last_tracks : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_served |-> last_ff == $signed({1'b0, rsp_served_value}))
      else $error("last served value does not match served beat");

   // A closed board never serves.
   a_closed_quiet : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_served && closed_ff))
      else $error("serve reported on a closed board");

endmodule

[sv/nvrs_cell.sv]
// One board slot of the scheduler: holds a request and updates the sweep token.
// Depends on nvrs_pkg.
module nvrs_cell #(
   parameter int Index = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  nvrs_pkg::sweep_type                sweep_i,
   output nvrs_pkg::sweep_type                sweep_o,
   input  logic                               in_range,
   input  logic signed [nvrs_pkg::LAST_W-1:0] last_served,
   input  nvrs_pkg::clear_type                clear
);
   import nvrs_pkg::*;

   logic               valid_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [OWNER_W-1:0] owner_ff;
   sweep_type          sweep_ff, sweep_in;

   logic               take;
   logic               valid_now;
   logic [VALUE_W-1:0] value_now;
   logic [OWNER_W-1:0] owner_now;
   logic signed [LAST_W:0] diff;
   logic [DIST_W-1:0]  gap;
   logic               better;

   // A pending post lands in the first free in-range slot the token meets.
   assign take      = sweep_i.active && sweep_i.pending && in_range && !valid_ff;
   assign valid_now = valid_ff || take;
   assign value_now = take ? sweep_i.value : value_ff;
   assign owner_now = take ? sweep_i.owner : owner_ff;

   assign diff = $signed({2'b00, value_now}) - $signed({last_served[LAST_W-1], last_served});
   assign gap  = diff[LAST_W] ? DIST_W'(-diff) : DIST_W'(diff);

   // Strict compare keeps the lowest slot on a tie.
   assign better = in_range && valid_now && (gap < sweep_i.best_dist);

   always_comb begin
      sweep_in           = sweep_i;
      sweep_in.pending   = sweep_i.pending && !take;
      sweep_in.free_seen = sweep_i.free_seen || (in_range && !valid_now);
      if (better) begin
         sweep_in.found      = 1'b1;
         sweep_in.best_dist  = gap;
         sweep_in.best_idx   = IDX_W'(Index);
         sweep_in.best_value = value_now;
         sweep_in.best_owner = owner_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff.active <= 1'b0;
         valid_ff        <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         if (take) begin
            valid_ff <= 1'b1;
         end else if (clear.en && clear.idx == IDX_W'(Index)) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         value_ff <= sweep_i.value;
         owner_ff <= sweep_i.owner;
      end
   end

   assign sweep_o = sweep_ff;

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for nearest_value_request_scheduler: a directed table of
// events, then random events, checked beat by beat against a scheduling predictor.
// Depends on nvrs_pkg and the scheduler RTL.
module tb_top;
   import nvrs_pkg::*;

   localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;
   localparam int EVENTS_PER_SEG = 58;

   typedef enum logic {ROW_EVENT, ROW_SIZE} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [OPCODE_W-1:0]  op;
      logic [OWNER_W-1:0]   who;
      logic [VALUE_W-1:0]   val;
      logic                 typed;
      logic [STATUS_W-1:0]  status;
   } plan_row_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                served;
      logic [OWNER_W-1:0]  who;
      logic [VALUE_W-1:0]  value;
   } outcome_type;

   // Rows with typed set carry a status that is plain from the rules and no serve.
   // For a size row, the low bits of val hold the board size.
   localparam plan_row_type PLAN [24] = '{
      '{ROW_EVENT, OP_POST,  4'd0,  10'd5,    1'b1, STAT_CLOSED},
      '{ROW_EVENT, OP_LEAVE, 4'd0,  10'd0,    1'b1, STAT_CLOSED},
      '{ROW_EVENT, OP_NOP,   4'd15, 10'd1023, 1'b1, STAT_CLOSED},
      '{ROW_EVENT, OP_JOIN,  4'd0,  10'd0,    1'b1, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd3,  10'd1023, 1'b1, STAT_RANGE},
      '{ROW_EVENT, OP_POST,  4'd3,  10'd1000, 1'b1, STAT_RANGE},
      '{ROW_EVENT, OP_JOIN,  4'd0,  10'd0,    1'b1, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd3,  10'd999,  1'b0, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd15, 10'd0,    1'b0, STAT_OK},
      '{ROW_EVENT, OP_JOIN,  4'd0,  10'd0,    1'b0, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd0,  10'd1,    1'b0, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd0,  10'd998,  1'b0, STAT_OK},
      '{ROW_EVENT, OP_LEAVE, 4'd0,  10'd0,    1'b0, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd7,  10'd998,  1'b0, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd9,  10'd997,  1'b0, STAT_OK},
      '{ROW_EVENT, OP_JOIN,  4'd0,  10'd0,    1'b0, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd2,  10'd500,  1'b0, STAT_OK},
      '{ROW_SIZE,  OP_POST,  4'd0,  10'd0,    1'b0, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd6,  10'd7,    1'b0, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd6,  10'd7,    1'b0, STAT_OK},
      '{ROW_SIZE,  OP_POST,  4'd0,  10'd31,   1'b0, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd12, 10'd3,    1'b0, STAT_OK},
      '{ROW_EVENT, OP_POST,  4'd12, 10'd996,  1'b0, STAT_OK},
      '{ROW_SIZE,  OP_POST,  4'd0,  10'd16,   1'b0, STAT_OK}
   };

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OPCODE_W-1:0] req_opcode;
   logic [OWNER_W-1:0]  req_requester;
   logic [VALUE_W-1:0]  req_value;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_served;
   logic [OWNER_W-1:0]  rsp_served_requester;
   logic [VALUE_W-1:0]  rsp_served_value;
   logic                csr_valid;
   logic                csr_ready;
   logic [SIZE_W-1:0]   csr_data;

   nearest_value_request_scheduler dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_opcode           (req_opcode),
      .req_requester        (req_requester),
      .req_value            (req_value),
      .rsp_valid            (rsp_valid),
      .rsp_status           (rsp_status),
      .rsp_served           (rsp_served),
      .rsp_served_requester (rsp_served_requester),
      .rsp_served_value     (rsp_served_value),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_data             (csr_data)
   );

   // Board state as the predictor sees it.
   logic               bd_valid [SLOTS_DEF];
   int                 bd_value [SLOTS_DEF];
   logic [OWNER_W-1:0] bd_owner [SLOTS_DEF];
   int                 bd_used;
   int                 bd_members;
   int                 bd_last;
   logic               bd_shut;
   logic [SIZE_W-1:0]  bd_size;

   outcome_type pending_outcomes [$];
   int          fail_count;
   int          sender_idle_pct;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int first_free_slot(input int span);
      for (int i = 0; i < span; i++)
         if (!bd_valid[i]) return i;
      return -1;
   endfunction

   function automatic outcome_type schedule_event(input logic [OPCODE_W-1:0] op,
                                                 input logic [OWNER_W-1:0] who,
                                                 input logic [VALUE_W-1:0] val);
      int          span;
      int          spot;
      int          pick;
      int          gap;
      int          best;
      outcome_type res;
      span = (bd_size == 0) ? 1 : (bd_size > SLOTS_DEF) ? SLOTS_DEF : int'(bd_size);
      res = '0;
      res.status = STAT_CLOSED;
      case (op)
         OP_POST: begin
            if (bd_shut || bd_members == 0) begin
               res.status = STAT_CLOSED;
            end else if (val >= VALUE_LIMIT) begin
               res.status = STAT_RANGE;
            end else begin
               spot = first_free_slot(span);
               if (spot < 0) begin
                  res.status = STAT_FULL;
               end else begin
                  bd_valid[spot] = 1'b1;
                  bd_value[spot] = int'(val);
                  bd_owner[spot] = who;
                  bd_used++;
                  res.status = STAT_OK;
               end
            end
         end
         OP_JOIN: begin
            if (bd_shut) res.status = STAT_CLOSED;
            else if (bd_members >= REQ_COUNT_DEF) res.status = STAT_FULL;
            else begin
               bd_members++;
               res.status = STAT_OK;
            end
         end
         OP_LEAVE: begin
            if (bd_shut || bd_members == 0) begin
               res.status = STAT_CLOSED;
            end else begin
               bd_members--;
               if (bd_members == 0) bd_shut = 1'b1;
               res.status = STAT_OK;
            end
         end
         default: ;
      endcase
      // A serve is attempted after every event, rejected ones included.
      if (!bd_shut && bd_used > 0 &&
          (first_free_slot(span) < 0 || bd_used == bd_members)) begin
         pick = -1;
         best = int'(DIST_START);
         for (int i = 0; i < span; i++) begin
            if (bd_valid[i]) begin
               gap = bd_value[i] - bd_last;
               if (gap < 0) gap = -gap;
               if (gap < best) begin
                  best = gap;
                  pick = i;
               end
            end
         end
         if (pick >= 0) begin
            bd_valid[pick] = 1'b0;
            bd_used--;
            bd_last = bd_value[pick];
            res.served = 1'b1;
            res.who = bd_owner[pick];
            res.value = bd_value[pick][VALUE_W-1:0];
         end
      end
      return res;
   endfunction

   // Drives one event, waits for it to be taken and records its outcome.
   // Start is left high so that a following event can go out back to back.
   task automatic issue_event(input logic [OPCODE_W-1:0] op,
                              input logic [OWNER_W-1:0] who,
                              input logic [VALUE_W-1:0] val);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(40, 1)) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_requester <= who;
      req_value <= val;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      pending_outcomes.push_back(schedule_event(op, who, val));
   endtask

   // The board size is only changed once every outstanding result has come back.
   task automatic program_board_size(input logic [SIZE_W-1:0] sz);
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= sz;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      csr_valid <= 1'b0;
      bd_size = sz;
   endtask

   always @(negedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $error("result beat with no event outstanding");
            fail_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_served !== want.served) begin
               $error("served: expected %0d, got %0d", want.served, rsp_served);
               fail_count++;
            end
            if (rsp_served_requester !== want.who) begin
               $error("served_requester: expected %0d, got %0d", want.who,
                      rsp_served_requester);
               fail_count++;
            end
            if (rsp_served_value !== want.value) begin
               $error("served_value: expected %0d, got %0d", want.value,
                      rsp_served_value);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      logic [OPCODE_W-1:0] op;
      logic [OWNER_W-1:0]  who;
      logic [VALUE_W-1:0]  val;
      logic [SIZE_W-1:0]   sz;
      outcome_type         typed_res;
      int                  roll;

      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_POST;
      req_requester = '0;
      req_value = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      fail_count = 0;
      sender_idle_pct = 32;
      for (int i = 0; i < SLOTS_DEF; i++) begin
         bd_valid[i] = 1'b0;
         bd_value[i] = 0;
         bd_owner[i] = '0;
      end
      bd_used = 0;
      bd_members = 0;
      bd_last = -1;
      bd_shut = 1'b0;
      bd_size = SIZE_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (PLAN[r]) begin
         if (PLAN[r].kind == ROW_SIZE) begin
            program_board_size(PLAN[r].val[SIZE_W-1:0]);
         end else begin
            issue_event(PLAN[r].op, PLAN[r].who, PLAN[r].val);
            if (PLAN[r].typed) begin
               typed_res = '0;
               typed_res.status = PLAN[r].status;
               pending_outcomes[pending_outcomes.size()-1] = typed_res;
            end
         end
      end

      // Random traffic in six stretches: three idling levels, two board sizes each.
      for (int seg = 0; seg < 6; seg++) begin
         sender_idle_pct = (seg < 2) ? 32 : (seg < 4) ? 56 : 0;
         case (seg)
            0, 2:    sz = SIZE_W'($urandom_range(15, 2));
            1:       sz = 5'd1;
            3:       sz = 5'd16;
            4:       sz = SIZE_W'($urandom_range(31, 0));
            default: sz = 5'd3;
         endcase
         program_board_size(sz);
         repeat (EVENTS_PER_SEG) begin
            roll = $urandom_range(99);
            who = OWNER_W'($urandom_range(15));
            val = VALUE_W'($urandom_range(999));
            // Leaves never drop the last requester here, so the board stays open.
            if (roll < 55) begin
               op = OP_POST;
            end else if (roll < 70) begin
               op = OP_JOIN;
            end else if (roll < 83) begin
               op = (bd_members > 1) ? OP_LEAVE : OP_JOIN;
            end else if (roll < 91) begin
               op = OP_POST;
               val = VALUE_W'($urandom_range(1023, 1000));
            end else if (roll < 94) begin
               op = OP_NOP;
            end else begin
               op = OPCODE_W'($urandom_range(3));
               val = VALUE_W'($urandom_range(1023));
               if (op == OP_LEAVE && bd_members <= 1) op = OP_JOIN;
            end
            issue_event(op, who, val);
         end
      end

      // Fill the requester roster, overflow it, then empty it so the board closes.
      sender_idle_pct = 32;
      while (bd_members < REQ_COUNT_DEF)
         issue_event(OP_JOIN, OWNER_W'($urandom_range(15)), VALUE_W'($urandom_range(1023)));
      issue_event(OP_JOIN, 4'd15, 10'd1023);
      while (bd_members > 0)
         issue_event(OP_LEAVE, OWNER_W'($urandom_range(15)), VALUE_W'($urandom_range(1023)));
      issue_event(OP_POST, 4'd15, 10'd999);
      issue_event(OP_JOIN, 4'd0, 10'd0);
      issue_event(OP_LEAVE, 4'd15, 10'd1023);
      issue_event(OP_NOP, 4'd0, 10'd0);
      start <= 1'b0;

      for (int w = 0; w < 2000 && pending_outcomes.size() != 0; w++) @(posedge clock);
      repeat (40) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d results never arrived", pending_outcomes.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[nearest_value_request_scheduler.f]
sv/nvrs_pkg.sv
sv/nvrs_cell.sv
sv/nearest_value_request_scheduler.sv
bench/tb_top.sv
